// File: src/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants of the stop-and-wait relay node.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swr_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QSUM_W      = QIDX_W + 1;
  localparam int unsigned RAM_DEPTH   = 2 * QUEUE_DEPTH;
  localparam int unsigned RAM_AW      = $clog2(RAM_DEPTH);

  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned HOP_W    = 8;
  localparam int unsigned ENTRY_W  = HANDLE_W + HOP_W;
  localparam int unsigned RND_W    = 16;
  localparam int unsigned THR_W    = 17;
  localparam int unsigned CFG_W    = THR_W;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);

  // configuration register indexes
  localparam logic CFG_ROUTE_THRESHOLD = 1'b0;
  localparam logic CFG_FINAL_NODE      = 1'b1;

  typedef enum logic [1:0] {
    REQ_DATA = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_NAK  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2,
    KIND_DROP = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SEL_ANSWER,
    SEL_FWD,
    SEL_HEAD
  } res_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ANSWER,
    ST_FWD,
    ST_HEAD
  } state_e;

  typedef struct packed {
    logic     capture;
    logic     commit;
    logic     load_out;
    res_sel_e sel;
    logic     last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ans_needed;
    logic fwd_result;
    logic head_tx;
    logic out_free;
  } dp_status_t;

endpackage

// File: src/stop_and_wait_relay_node.sv
// ----------------------------------------------------------------------------
// stop_and_wait_relay_node
// Two-port stop-and-wait relay: answers, queues and forwards packet handles.
// Results: the first loads into the output register in the answer, forward or
// head state after decode; so does a queue-head resend (RAM read in decode).
// Flow: a new item is taken only in idle, after the decode step of the
// controller and one output slot per result; output stalls hold the controller.
// Reset: asynchronous, active low; clears queue pointers and counts, config
// returns to its reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stop_and_wait_relay_node
  import swr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          req_type_i,
  input  logic                from_source_i,
  input  logic                arrival_port_i,
  input  logic [HANDLE_W-1:0] packet_handle_i,
  input  logic [HOP_W-1:0]    hop_count_i,
  input  logic                bit_error_i,
  input  logic [RND_W-1:0]    random_value_i,
  input  logic [1:0]          channel_busy_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          out_kind_o,
  output logic                out_port_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [HOP_W-1:0]    out_hop_count_o,
  output logic                last_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  swr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .from_source_i   (from_source_i),
    .arrival_port_i  (arrival_port_i),
    .packet_handle_i (packet_handle_i),
    .hop_count_i     (hop_count_i),
    .bit_error_i     (bit_error_i),
    .random_value_i  (random_value_i),
    .channel_busy_i  (channel_busy_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_kind_o      (out_kind_o),
    .out_port_o      (out_port_o),
    .out_handle_o    (out_handle_o),
    .out_hop_count_o (out_hop_count_o),
    .last_o          (last_o)
  );

`ifndef SYNTHESIS
  // every transfer in is followed by the decode step
  a_decode_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (cmd.commit && !in_ready_o))
    else $error("decode step did not follow an input transfer");

  // a result never overwrites one that has not been transferred
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> status.out_free)
    else $error("output register loaded while still holding a result");

  // no new item while the decode step is running
  a_commit_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!in_ready_o && !cmd.load_out))
    else $error("input taken or result loaded during decode");
`endif

endmodule

// File: src/swr_ram.sv
// ----------------------------------------------------------------------------
// swr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/swr_ctrl.sv
// ----------------------------------------------------------------------------
// swr_ctrl
// Controller: accepts one item, decodes it, then issues up to two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swr_ctrl
  import swr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   plan_fwd_q, plan_fwd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      plan_fwd_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      plan_fwd_q <= plan_fwd_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    plan_fwd_d = plan_fwd_q;
    in_ready_o = 1'b0;
    cmd_o      = '{capture: 1'b0, commit: 1'b0, load_out: 1'b0,
                   sel: SEL_ANSWER, last: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        // queue update and head read happen here, so the plan is kept
        cmd_o.commit = 1'b1;
        plan_fwd_d   = status_i.fwd_result;
        if (status_i.ans_needed) begin
          state_d = ST_ANSWER;
        end else if (status_i.fwd_result) begin
          state_d = ST_FWD;
        end else if (status_i.head_tx) begin
          state_d = ST_HEAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ANSWER: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.sel      = SEL_ANSWER;
          cmd_o.last     = !plan_fwd_q;
          state_d        = plan_fwd_q ? ST_FWD : ST_IDLE;
        end
      end
      ST_FWD: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.sel      = SEL_FWD;
          cmd_o.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_HEAD: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.sel      = SEL_HEAD;
          cmd_o.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/swr_datapath.sv
// ----------------------------------------------------------------------------
// swr_datapath
// Item and config registers, per-port queues in RAM, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swr_datapath
  import swr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic [1:0]          req_type_i,
  input  logic                from_source_i,
  input  logic                arrival_port_i,
  input  logic [HANDLE_W-1:0] packet_handle_i,
  input  logic [HOP_W-1:0]    hop_count_i,
  input  logic                bit_error_i,
  input  logic [RND_W-1:0]    random_value_i,
  input  logic [1:0]          channel_busy_i,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          out_kind_o,
  output logic                out_port_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [HOP_W-1:0]    out_hop_count_o,
  output logic                last_o
);

  // configuration
  logic [THR_W-1:0] thr_q;
  logic             final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RESET;
      final_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROUTE_THRESHOLD: thr_q   <= cfg_data_i;
        CFG_FINAL_NODE:      final_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [1:0]          req_q;
  logic                src_q;
  logic                aport_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [HOP_W-1:0]    hop_q;
  logic                err_q;
  logic [RND_W-1:0]    rnd_q;
  logic [1:0]          busy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q    <= req_type_i;
      src_q    <= from_source_i;
      aport_q  <= arrival_port_i;
      handle_q <= packet_handle_i;
      hop_q    <= hop_count_i;
      err_q    <= bit_error_i;
      rnd_q    <= random_value_i;
      busy_q   <= channel_busy_i;
    end
  end

  // queue state
  logic [QIDX_W-1:0] head_q  [2];
  logic [QIDX_W-1:0] head_d  [2];
  logic [QCNT_W-1:0] count_q [2];
  logic [QCNT_W-1:0] count_d [2];

  logic [HOP_W-1:0]  hop_inc;
  logic              is_data, is_ack, is_nak;
  logic              ans_needed, fwd_needed, fwd_port, fwd_full, fwd_tx, fwd_write;
  logic              ack_pop, ack_tx, nak_tx, head_tx;
  logic [QCNT_W-1:0] fwd_cnt, a_cnt;
  logic [QIDX_W-1:0] fwd_head, a_head, a_head_inc, tail, rd_idx;
  logic [QSUM_W-1:0] tail_sum;
  logic [RAM_AW-1:0] waddr, raddr;
  logic [ENTRY_W-1:0] rdata;
  logic              drop_q;

  assign hop_inc = (hop_q == '1) ? hop_q : hop_q + HOP_W'(1);
  assign is_data = (req_q == REQ_DATA);
  assign is_ack  = (req_q == REQ_ACK);
  assign is_nak  = (req_q == REQ_NAK);

  assign ans_needed = is_data && (final_q || !src_q);
  assign fwd_needed = !final_q && (src_q || (is_data && !err_q));
  assign fwd_port   = ({1'b0, rnd_q} < thr_q) ? 1'b0 : 1'b1;
  assign fwd_cnt    = count_q[fwd_port];
  assign fwd_head   = head_q[fwd_port];
  assign fwd_full   = (fwd_cnt >= QCNT_W'(QUEUE_DEPTH));
  // a packet entering an empty queue is sent straight from the item registers, unless its channel is busy
  assign fwd_tx     = !fwd_full && (fwd_cnt == '0) && !busy_q[fwd_port];
  assign fwd_write  = fwd_needed && !fwd_full;

  assign a_cnt      = count_q[aport_q];
  assign a_head     = head_q[aport_q];
  assign a_head_inc = (a_head == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : a_head + QIDX_W'(1);
  assign ack_pop    = !final_q && !src_q && is_ack && (a_cnt != '0);
  assign ack_tx     = ack_pop && (a_cnt > QCNT_W'(1)) && !busy_q[aport_q];
  assign nak_tx     = !final_q && !src_q && is_nak && (a_cnt != '0) && !busy_q[aport_q];
  assign head_tx    = ack_tx || nak_tx;
  assign rd_idx     = is_ack ? a_head_inc : a_head;

  always_comb begin
    tail_sum = QSUM_W'(fwd_head) + QSUM_W'(fwd_cnt);
    if (tail_sum >= QSUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - QSUM_W'(QUEUE_DEPTH);
    end
    tail = tail_sum[QIDX_W-1:0];
  end

  assign waddr = fwd_port ? RAM_AW'(QUEUE_DEPTH) + RAM_AW'(tail) : RAM_AW'(tail);
  assign raddr = aport_q ? RAM_AW'(QUEUE_DEPTH) + RAM_AW'(rd_idx) : RAM_AW'(rd_idx);

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      head_d[p]  = head_q[p];
      count_d[p] = count_q[p];
      if (cmd_i.commit) begin
        if (fwd_write && (fwd_port == 1'(p))) begin
          count_d[p] = count_q[p] + QCNT_W'(1);
        end else if (ack_pop && (aport_q == 1'(p))) begin
          head_d[p]  = a_head_inc;
          count_d[p] = count_q[p] - QCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < 2; p++) begin
        head_q[p]  <= '0;
        count_q[p] <= '0;
      end
    end else begin
      for (int p = 0; p < 2; p++) begin
        head_q[p]  <= head_d[p];
        count_q[p] <= count_d[p];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      drop_q <= fwd_full;
    end
  end

  swr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && fwd_write),
    .waddr_i (waddr),
    .wdata_i ({hop_inc, handle_q}),
    .re_i    (cmd_i.commit),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // output register
  logic                out_valid_q;
  logic [1:0]          out_kind_q;
  logic                out_port_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic [HOP_W-1:0]    out_hop_q;
  logic                last_q;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      last_q <= cmd_i.last;
      case (cmd_i.sel)
        SEL_FWD: begin
          out_kind_q   <= drop_q ? KIND_DROP : KIND_DATA;
          out_port_q   <= fwd_port;
          out_handle_q <= handle_q;
          out_hop_q    <= hop_inc;
        end
        SEL_HEAD: begin
          out_kind_q   <= KIND_DATA;
          out_port_q   <= aport_q;
          out_handle_q <= rdata[HANDLE_W-1:0];
          out_hop_q    <= rdata[ENTRY_W-1:HANDLE_W];
        end
        default: begin
          out_kind_q   <= err_q ? KIND_NAK : KIND_ACK;
          out_port_q   <= aport_q;
          out_handle_q <= '0;
          out_hop_q    <= '0;
        end
      endcase
    end
  end

  assign status_o = '{ans_needed: ans_needed, fwd_result: fwd_needed && (fwd_full || fwd_tx),
                      head_tx: head_tx, out_free: out_free};

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = out_kind_q;
  assign out_port_o      = out_port_q;
  assign out_handle_o    = out_handle_q;
  assign out_hop_count_o = out_hop_q;
  assign last_o          = last_q;

endmodule

// File: sim/tb_stop_and_wait_relay_node.sv
// ----------------------------------------------------------------------------
// tb_stop_and_wait_relay_node
// Self-checking bench for the stop-and-wait relay node. A scoreboard class
// keeps its own copy of the two port queues and the settings, predicts the
// answers, transmits and drops for every item transfer, and checks the
// result stream in order. Directed items come first, then random phases
// under several routing thresholds and both node modes, with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stop_and_wait_relay_node;
  import swr_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    kind_e               kind;
    logic                port;
    logic [HANDLE_W-1:0] handle;
    logic [HOP_W-1:0]    hop;
    logic                last;
  } relay_result_t;

  typedef struct {
    logic [HANDLE_W-1:0] handle;
    logic [HOP_W-1:0]    hop;
  } queued_pkt_t;

  // percentages of each item class, the remainder is the unused kind
  typedef struct {
    int clean;
    int errored;
    int source;
    int ack;
    int nak;
  } item_mix_t;

  class relay_scoreboard;
    queued_pkt_t      port_fifo[2][$];
    relay_result_t    expected_q[$];
    relay_result_t    staged[$];
    logic [THR_W-1:0] threshold;
    bit               final_mode;
    bit               touched;
    int               errors;

    function new();
      threshold  = THR_RESET;
      final_mode = 1'b0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int depth(logic port);
      return port_fifo[port].size();
    endfunction

    function void stage(kind_e kind, logic port, logic [HANDLE_W-1:0] handle,
                        logic [HOP_W-1:0] hop);
      relay_result_t r;
      r.kind   = kind;
      r.port   = port;
      r.handle = handle;
      r.hop    = hop;
      r.last   = 1'b0;
      staged.push_back(r);
    endfunction

    function void send_head(logic port, logic [1:0] busy);
      if (port_fifo[port].size() != 0 && !busy[port]) begin
        stage(KIND_DATA, port, port_fifo[port][0].handle, port_fifo[port][0].hop);
      end
    endfunction

    function void forward(logic [HANDLE_W-1:0] handle, logic [HOP_W-1:0] hop,
                          logic [RND_W-1:0] rnd, logic [1:0] busy);
      logic        port;
      queued_pkt_t pkt;
      port    = ({1'b0, rnd} < threshold) ? 1'b0 : 1'b1;
      touched = 1'b1;
      if (port_fifo[port].size() >= QUEUE_DEPTH) begin
        stage(KIND_DROP, port, handle, hop);
      end else begin
        pkt.handle = handle;
        pkt.hop    = hop;
        port_fifo[port].push_back(pkt);
        // only a packet entering an empty queue goes out right away
        if (port_fifo[port].size() == 1) begin
          send_head(port, busy);
        end
      end
    endfunction

    // returns 1 when the item changed state or caused a result
    function bit note_item(logic [1:0] req, logic src, logic aport,
                           logic [HANDLE_W-1:0] handle, logic [HOP_W-1:0] hop,
                           logic err, logic [RND_W-1:0] rnd, logic [1:0] busy);
      logic [HOP_W-1:0] hop_up;
      hop_up = (hop == '1) ? hop : hop + 1'b1;
      staged.delete();
      touched = 1'b0;
      if (final_mode) begin
        if (req == REQ_DATA) begin
          stage(err ? KIND_NAK : KIND_ACK, aport, '0, '0);
        end
      end else if (src) begin
        forward(handle, hop_up, rnd, busy);
      end else if (req == REQ_DATA) begin
        if (err) begin
          stage(KIND_NAK, aport, '0, '0);
        end else begin
          stage(KIND_ACK, aport, '0, '0);
          forward(handle, hop_up, rnd, busy);
        end
      end else if (req == REQ_ACK) begin
        if (port_fifo[aport].size() != 0) begin
          port_fifo[aport].delete(0);
          touched = 1'b1;
          send_head(aport, busy);
        end
      end else if (req == REQ_NAK) begin
        send_head(aport, busy);
      end
      if (staged.size() != 0) begin
        staged[staged.size() - 1].last = 1'b1;
      end
      foreach (staged[i]) begin
        expected_q.push_back(staged[i]);
      end
      return touched || (staged.size() != 0);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
        end
      end
    endfunction

    function void check_result(relay_result_t got);
      relay_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected result: expected none, actual kind %0d port %0d handle %0d hop %0d",
                   $time, got.kind, got.port, got.handle, got.hop);
        end
      end else begin
        want = expected_q.pop_front();
        compare_field("out_kind", want.kind, got.kind);
        compare_field("out_port", want.port, got.port);
        compare_field("out_handle", want.handle, got.handle);
        compare_field("out_hop_count", want.hop, got.hop);
        compare_field("last", want.last, got.last);
      end
    endfunction

    function void report_leftover();
      foreach (expected_q[i]) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: missing result: expected kind %0d port %0d handle %0d hop %0d, actual none",
                   $time, expected_q[i].kind, expected_q[i].port, expected_q[i].handle,
                   expected_q[i].hop);
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = CFG_ROUTE_THRESHOLD;
  logic [CFG_W-1:0]    cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          req_type_i = REQ_DATA;
  logic                from_source_i = 1'b0;
  logic                arrival_port_i = 1'b0;
  logic [HANDLE_W-1:0] packet_handle_i = '0;
  logic [HOP_W-1:0]    hop_count_i = '0;
  logic                bit_error_i = 1'b0;
  logic [RND_W-1:0]    random_value_i = '0;
  logic [1:0]          channel_busy_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          out_kind_o;
  logic                out_port_o;
  logic [HANDLE_W-1:0] out_handle_o;
  logic [HOP_W-1:0]    out_hop_count_o;
  logic                last_o;

  relay_scoreboard sb;
  int              send_idle_pct = 21;
  int              recv_idle_pct = 79;
  int              random_count = 0;

  stop_and_wait_relay_node dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .from_source_i   (from_source_i),
    .arrival_port_i  (arrival_port_i),
    .packet_handle_i (packet_handle_i),
    .hop_count_i     (hop_count_i),
    .bit_error_i     (bit_error_i),
    .random_value_i  (random_value_i),
    .channel_busy_i  (channel_busy_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_kind_o      (out_kind_o),
    .out_port_o      (out_port_o),
    .out_handle_o    (out_handle_o),
    .out_hop_count_o (out_hop_count_o),
    .last_o          (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: check each transfer, then pick the next ready
  initial begin : result_monitor
    relay_result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.kind   = kind_e'(out_kind_o);
        got.port   = out_port_o;
        got.handle = out_handle_o;
        got.hop    = out_hop_count_o;
        got.last   = last_o;
        sb.check_result(got);
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic update_idling();
    case (random_count * 3 / RANDOM_ITEMS)
      0: begin
        send_idle_pct = 21;
        recv_idle_pct = 79;
      end
      1: begin
        send_idle_pct = 79;
        recv_idle_pct = 21;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FINAL_NODE) begin
      sb.final_mode = value[0];
    end else begin
      sb.threshold = value[THR_W-1:0];
    end
    @(posedge clk_i);
  endtask

  // hold off the sender until every expected result has arrived
  task automatic settle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic drive_item(logic [1:0] req, logic src, logic aport,
                            logic [HANDLE_W-1:0] handle, logic [HOP_W-1:0] hop,
                            logic err, logic [RND_W-1:0] rnd, logic [1:0] busy,
                            output bit took);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    from_source_i   <= src;
    arrival_port_i  <= aport;
    packet_handle_i <= handle;
    hop_count_i     <= hop;
    bit_error_i     <= err;
    random_value_i  <= rnd;
    channel_busy_i  <= busy;
    do @(posedge clk_i); while (!in_ready_o);
    took = sb.note_item(req, src, aport, handle, hop, err, rnd, busy);
  endtask

  task automatic directed_items();
    bit took;
    // clean link packets at the field extremes, hop saturation on the second
    drive_item(REQ_DATA, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, 2'b00, took);
    drive_item(REQ_DATA, 1'b0, 1'b1, 16'hFFFF, 8'hFF, 1'b0, 16'hFFFF, 2'b00, took);
    // source flag wins over the ack kind
    drive_item(REQ_ACK, 1'b1, 1'b0, 16'h1234, 8'hFE, 1'b1, 16'h7FFF, 2'b00, took);
    drive_item(REQ_DATA, 1'b0, 1'b1, 16'hA5A5, 8'h10, 1'b1, 16'h5A5A, 2'b11, took);
    drive_item(REQ_UNUSED, 1'b0, 1'b0, 16'h0F0F, 8'h55, 1'b0, 16'h1111, 2'b00, took);
    // resend held off by a busy channel, then allowed
    drive_item(REQ_NAK, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, 2'b01, took);
    drive_item(REQ_NAK, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, 2'b00, took);
    drive_item(REQ_ACK, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, 2'b10, took);
    drive_item(REQ_ACK, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, 2'b01, took);
    // ack and nak on an empty queue
    drive_item(REQ_ACK, 1'b0, 1'b0, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 2'b00, took);
    drive_item(REQ_NAK, 1'b0, 1'b0, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 2'b00, took);
    drive_item(REQ_NAK, 1'b1, 1'b1, 16'h5A5A, 8'h7F, 1'b0, 16'h8000, 2'b00, took);
    drive_item(REQ_ACK, 1'b0, 1'b1, 16'h0000, 8'h00, 1'b0, 16'h0000, 2'b10, took);
    drive_item(REQ_NAK, 1'b0, 1'b1, 16'h0000, 8'h00, 1'b0, 16'h0000, 2'b00, took);
    drive_item(REQ_ACK, 1'b0, 1'b1, 16'h0000, 8'h00, 1'b0, 16'h0000, 2'b00, took);
    // forward onto a busy idle queue, released by a nak
    drive_item(REQ_DATA, 1'b0, 1'b1, 16'h00FF, 8'h80, 1'b0, 16'h0000, 2'b11, took);
    drive_item(REQ_NAK, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, 2'b00, took);
    drive_item(REQ_ACK, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, 2'b00, took);
  endtask

  task automatic random_item(item_mix_t mix, output bit took);
    int                  pick;
    int                  edge_rnd;
    logic [1:0]          req;
    logic                src;
    logic                aport;
    logic                err;
    logic [HANDLE_W-1:0] handle;
    logic [HOP_W-1:0]    hop;
    logic [RND_W-1:0]    rnd;
    logic [1:0]          busy;
    pick   = $urandom_range(0, 99);
    req    = REQ_DATA;
    src    = 1'b0;
    err    = 1'b0;
    aport  = 1'($urandom_range(0, 1));
    handle = HANDLE_W'($urandom);
    hop    = ($urandom_range(0, 6) == 0) ? HOP_W'(254 + $urandom_range(0, 1)) : HOP_W'($urandom);
    busy   = ($urandom_range(0, 1) != 0) ? 2'($urandom_range(0, 3)) : 2'b00;
    if ($urandom_range(0, 3) == 0) begin
      // land right on either side of the routing threshold
      edge_rnd = int'(sb.threshold) - int'($urandom_range(0, 1));
      if (edge_rnd < 0) edge_rnd = 0;
      if (edge_rnd > 65535) edge_rnd = 65535;
      rnd = RND_W'(edge_rnd);
    end else begin
      rnd = RND_W'($urandom);
    end
    if (pick < mix.clean) begin
      req = REQ_DATA;
    end else if (pick < mix.clean + mix.errored) begin
      err = 1'b1;
    end else if (pick < mix.clean + mix.errored + mix.source) begin
      src = 1'b1;
      req = 2'($urandom_range(0, 3));
      err = 1'($urandom_range(0, 1));
    end else if (pick < mix.clean + mix.errored + mix.source + mix.ack + mix.nak) begin
      req = (pick < mix.clean + mix.errored + mix.source + mix.ack) ? REQ_ACK : REQ_NAK;
      err = 1'($urandom_range(0, 1));
      // mostly aim replies at a port that has something queued
      if (sb.depth(aport) == 0 && sb.depth(!aport) != 0 && $urandom_range(0, 4) != 0) begin
        aport = !aport;
      end
    end else begin
      req = REQ_UNUSED;
      err = 1'($urandom_range(0, 1));
    end
    drive_item(req, src, aport, handle, hop, err, rnd, busy, took);
  endtask

  task automatic run_phase(logic [THR_W-1:0] thr, logic fin, item_mix_t mix, int target);
    int done;
    bit took;
    done = 0;
    write_cfg(CFG_ROUTE_THRESHOLD, CFG_W'(thr));
    write_cfg(CFG_FINAL_NODE, CFG_W'(fin));
    // every transfer counts, items without effect included
    while (done < target) begin
      random_item(mix, took);
      done++;
      random_count++;
      update_idling();
    end
    settle();
  endtask

  initial begin : stimulus
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    update_idling();
    directed_items();
    settle();
    run_phase(THR_W'(32768), 1'b0, '{30, 8, 15, 30, 12}, 350);
    // everything to port zero with few acks: queue fills and drops
    run_phase(THR_W'(65536), 1'b0, '{40, 5, 30, 10, 10}, 300);
    // everything to port one, with mostly acks to drain
    run_phase(THR_W'(0), 1'b0, '{15, 5, 10, 55, 12}, 300);
    run_phase(THR_W'(1), 1'b1, '{30, 20, 15, 15, 15}, 250);
    run_phase(THR_W'(65535), 1'b0, '{40, 5, 30, 10, 10}, 300);
    run_phase(THR_W'($urandom_range(0, 65536)), 1'b0, '{30, 8, 15, 30, 12}, 250);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
